@@ hw/rtl/box_filter_replicate_border_defines.svh @@
// assertion macros used by the checker of the box filter
`ifndef BOX_FILTER_REPLICATE_BORDER_DEFINES_SVH
`define BOX_FILTER_REPLICATE_BORDER_DEFINES_SVH

// same-cycle implication, disabled while rst_sig is high
`define BFRB_ASSERT_IMP(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("box filter check failed");

// next-cycle implication, disabled while rst_sig is high
`define BFRB_ASSERT_NXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("box filter check failed");

`endif

@@ hw/rtl/bfrb_pkg.sv @@
package bfrb_pkg;

  // frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // field and counter widths
  localparam int PIX_W        = 8;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int MEM_W        = 2 * PIX_W;
  localparam int VSUM_W       = 10;
  localparam int HSUM_W       = 12;
  localparam int PROD_W       = 24;

  // register reset values and saturation limits
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX    = WIDTH_REG_W'(MAX_WIDTH);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = HEIGHT_REG_W'(MAX_HEIGHT);

  // divide by nine: (sum * 3641) >> 15 is exact for sums below 2304
  localparam logic [HSUM_W-1:0] MEAN_RECIP = HSUM_W'(3641);
  localparam int                MEAN_SHIFT = 15;

  // register map, index is paddr[2]
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // results one input can cause, in raster order
  typedef enum logic [1:0] {
    RES_UP_LEFT  = 2'd0,
    RES_UP_RIGHT = 2'd1,
    RES_LO_LEFT  = 2'd2,
    RES_LO_RIGHT = 2'd3
  } res_slot_t;

endpackage

@@ hw/rtl/box_filter_replicate_border.sv @@
// channel | signals                                         | transfer when
// --------+-------------------------------------------------+------------------------------
// pixel   | pixel_valid, pixel_ready, pixel_in              | pixel_valid & pixel_ready
// result  | result_valid, result_ready, mean_pixel,         | result_valid & result_ready
//         | run_last, frame_last                            |
// config  | psel, penable, pwrite, paddr, pwdata, prdata,   | psel & penable & pwrite
//         | pready                                          |
//
// one pixel per cycle while the pipe is not stalled; a pixel with k results holds the expander
// until all k are out (k <= 4, more than one only on the last column or the last row)
// first result of a pixel: line memory read and stage 1 loaded at the transfer edge, then
// vertical sum into stage 2, horizontal sum into stage 3, divide into the output register
// rst is synchronous; the line memory is not cleared, rows are read only once written
// result_ready low stalls the pipe back to pixel_ready; a register write restarts the frame
module box_filter_replicate_border import bfrb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  logic [PIX_W-1:0]  pixel_in,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [PIX_W-1:0]  mean_pixel,
  output logic              run_last,
  output logic              frame_last
);

  typedef struct packed {
    logic       c_ge1;
    logic       c_ge2;
    logic       r_ge1;
    logic       r_ge2;
    logic [3:0] mask;
    logic       frame_end;
  } pos_t;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [WIDTH_REG_W-1:0]  width_m1;
  logic [HEIGHT_REG_W-1:0] height_m1;
  logic [COL_W-1:0]        width_last;
  logic [ROW_W-1:0]        height_last;
  logic                    cfg_write;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             accept;
  logic             at_last_col;
  logic             at_last_row;
  pos_t             pos_in;

  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] mem_rdata;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] fwd_data;
  logic             fwd_hit;
  logic [MEM_W-1:0] col_word;
  logic [PIX_W-1:0] p1;
  logic [PIX_W-1:0] p2;

  logic             v1;
  logic [PIX_W-1:0] s1_pix;
  logic [COL_W-1:0] s1_col;
  pos_t             s1_pos;
  logic             s1_move;
  logic             s1_free;
  logic [VSUM_W-1:0] vu;
  logic [VSUM_W-1:0] vl;
  logic [VSUM_W-1:0] hu1, hu2, hl1, hl2;

  logic              v2;
  pos_t              s2_pos;
  logic [VSUM_W-1:0] s2_vu, s2_hu1, s2_hu2, s2_vl, s2_hl1, s2_hl2;
  logic              s2_move;
  logic              s2_free;
  logic [HSUM_W-1:0] sum_ul, sum_ur, sum_ll, sum_lr;

  logic [3:0]        mask3;
  logic              s3_fl;
  logic [HSUM_W-1:0] s3_sum [4];
  logic [3:0]        rem;
  logic              s3_free;
  logic              emit;
  res_slot_t         sel;
  logic [PROD_W-1:0] prod;
  logic              o_free;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[2]))
        REG_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_WIDTH:  prdata = DATA_W'(image_width);
      REG_HEIGHT: prdata = DATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // effective frame size, saturated to the supported range
  assign width_m1  = image_width - WIDTH_REG_W'(1);
  assign height_m1 = image_height - HEIGHT_REG_W'(1);

  always_comb begin
    if (image_width == '0) begin
      width_last = '0;
    end else if (image_width > WIDTH_MAX) begin
      width_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last = width_m1[COL_W-1:0];
    end
    if (image_height == '0) begin
      height_last = '0;
    end else if (image_height > HEIGHT_MAX) begin
      height_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last = height_m1[ROW_W-1:0];
    end
  end

  // input position and which results this pixel completes
  assign accept      = pixel_valid & pixel_ready;
  assign at_last_col = (col_count == width_last);
  assign at_last_row = (row_count == height_last);

  always_comb begin
    pos_in.c_ge1     = (col_count != '0);
    pos_in.c_ge2     = (col_count > COL_W'(1));
    pos_in.r_ge1     = (row_count != '0);
    pos_in.r_ge2     = (row_count > ROW_W'(1));
    pos_in.mask[RES_UP_LEFT]  = pos_in.r_ge1 & pos_in.c_ge1;
    pos_in.mask[RES_UP_RIGHT] = pos_in.r_ge1 & at_last_col;
    pos_in.mask[RES_LO_LEFT]  = at_last_row & pos_in.c_ge1;
    pos_in.mask[RES_LO_RIGHT] = at_last_row & at_last_col;
    pos_in.frame_end = at_last_row & at_last_col;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_count <= '0;
        row_count <= at_last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // line memory: per column the two rows above, read on transfer, written back from stage 1
  assign mem_wdata = {s1_pix, p1};

  always_ff @(posedge clk) begin
    if (s1_move) begin
      line_mem[s1_col] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= line_mem[col_count];
    end
  end

  // forward a write-back to the same column (single-column frames)
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= s1_move && (s1_col == col_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= mem_wdata;
    end
  end

  assign col_word = fwd_hit ? fwd_data : mem_rdata;
  assign p1       = col_word[MEM_W-1:PIX_W];
  assign p2       = col_word[PIX_W-1:0];

  // pipeline flow control
  assign o_free      = !result_valid || result_ready;
  assign s2_free     = !v2 || s3_free;
  assign s2_move     = v2 && s3_free;
  assign s1_free     = !v1 || s2_free;
  assign s1_move     = v1 && s2_free;
  assign pixel_ready = s1_free;

  // stage 1: pixel and position
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (s1_move) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel_in;
      s1_col <= col_count;
      s1_pos <= pos_in;
    end
  end

  // vertical sums with rows clamped to the frame
  assign vu = VSUM_W'(s1_pos.r_ge2 ? p2 : p1) + VSUM_W'(p1) + VSUM_W'(s1_pix);
  assign vl = VSUM_W'(s1_pos.r_ge1 ? p1 : s1_pix) + VSUM_W'(s1_pix) + VSUM_W'(s1_pix);

  // column history and stage 2 registers
  always_ff @(posedge clk) begin
    if (s1_move) begin
      hu1    <= vu;
      hu2    <= hu1;
      hl1    <= vl;
      hl2    <= hl1;
      s2_vu  <= vu;
      s2_hu1 <= hu1;
      s2_hu2 <= hu2;
      s2_vl  <= vl;
      s2_hl1 <= hl1;
      s2_hl2 <= hl2;
      s2_pos <= s1_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s1_move) begin
      v2 <= 1'b1;
    end else if (s2_move) begin
      v2 <= 1'b0;
    end
  end

  // horizontal sums with columns clamped to the frame
  assign sum_ul = HSUM_W'(s2_pos.c_ge2 ? s2_hu2 : s2_hu1) + HSUM_W'(s2_hu1) + HSUM_W'(s2_vu);
  assign sum_ur = HSUM_W'(s2_pos.c_ge1 ? s2_hu1 : s2_vu) + HSUM_W'(s2_vu) + HSUM_W'(s2_vu);
  assign sum_ll = HSUM_W'(s2_pos.c_ge2 ? s2_hl2 : s2_hl1) + HSUM_W'(s2_hl1) + HSUM_W'(s2_vl);
  assign sum_lr = HSUM_W'(s2_pos.c_ge1 ? s2_hl1 : s2_vl) + HSUM_W'(s2_vl) + HSUM_W'(s2_vl);

  // stage 3: expander, one result per cycle while the output register is free, in raster order
  assign rem     = mask3 & (mask3 - 4'd1);
  assign emit    = (mask3 != '0) && o_free;
  assign s3_free = (mask3 == '0) || (o_free && (rem == '0));

  always_comb begin
    if (mask3[RES_UP_LEFT]) begin
      sel = RES_UP_LEFT;
    end else if (mask3[RES_UP_RIGHT]) begin
      sel = RES_UP_RIGHT;
    end else if (mask3[RES_LO_LEFT]) begin
      sel = RES_LO_LEFT;
    end else begin
      sel = RES_LO_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask3 <= '0;
    end else if (s2_move) begin
      mask3 <= s2_pos.mask;
    end else if (emit) begin
      mask3 <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_sum[RES_UP_LEFT]  <= sum_ul;
      s3_sum[RES_UP_RIGHT] <= sum_ur;
      s3_sum[RES_LO_LEFT]  <= sum_ll;
      s3_sum[RES_LO_RIGHT] <= sum_lr;
      s3_fl                <= s2_pos.frame_end;
    end
  end

  // divide by the kernel area into the output register
  assign prod = PROD_W'(s3_sum[sel]) * PROD_W'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mean_pixel <= prod[MEAN_SHIFT +: PIX_W];
      run_last   <= (rem == '0);
      frame_last <= s3_fl && (sel == RES_LO_RIGHT);
    end
  end

endmodule

@@ hw/rtl/bfrb_checker.sv @@
`include "box_filter_replicate_border_defines.svh"

module bfrb_checker import bfrb_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [PIX_W-1:0] mean_pixel,
  input logic             run_last,
  input logic             frame_last
);

  logic             out_stall;
  logic [PIX_W+1:0] out_word;

  assign out_stall = result_valid && !result_ready;
  assign out_word  = {mean_pixel, run_last, frame_last};

  // reset empties the output register
  `BFRB_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !result_valid)

  // the frame's final result also closes its run
  `BFRB_ASSERT_IMP(a_frame_ends_run, clk, rst, result_valid && frame_last, run_last)

  // a stalled result holds
  `BFRB_ASSERT_NXT(a_stall_hold, clk, rst, out_stall, result_valid && $stable(out_word))

  // the config port never waits
  `BFRB_ASSERT_IMP(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind box_filter_replicate_border bfrb_checker u_bfrb_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .mean_pixel   (mean_pixel),
  .run_last     (run_last),
  .frame_last   (frame_last)
);

@@ bench/tb_box_filter_replicate_border.sv @@
`timescale 1ns / 100ps

module tb_box_filter_replicate_border;
  import bfrb_pkg::*;

  localparam int KSIZE = 3;
  localparam int HALF  = KSIZE / 2;
  localparam int NUM_RANDOM = 130;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             run_end;
    logic             frame_end;
  } mean_result_t;

  // directed stimulus row: pixel, and an optional known result
  typedef struct {
    logic [PIX_W-1:0] pix;
    bit               known;
    mean_result_t     res;
  } pixel_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              pixel_valid;
  logic              pixel_ready;
  logic [PIX_W-1:0]  pixel_in;
  logic              result_valid;
  logic              result_ready;
  logic [PIX_W-1:0]  mean_pixel;
  logic              run_last;
  logic              frame_last;

  // predictor state
  logic [PIX_W-1:0]        rows_mem [KSIZE][MAX_WIDTH];
  logic [WIDTH_REG_W-1:0]  cfg_width;
  logic [HEIGHT_REG_W-1:0] cfg_height;
  int                      next_col;
  int                      next_row;

  mean_result_t pending_means[$];
  int           error_count;
  int           result_count;
  int           frame_count;
  bit           hold_results_checked;

  box_filter_replicate_border DUT (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit
  initial begin
    #20ms;
    $display("timeout");
    $display("tb_box_filter_replicate_border NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, result_count);
    error_count++;
  endtask

  function automatic int eff_dim(input int v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int clamp_to(input int v, input int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] box_mean(input int r, input int c,
                                                input int w, input int h);
    int acc;
    int rr;
    acc = 0;
    for (int dr = -HALF; dr <= HALF; dr++) begin
      rr = clamp_to(r + dr, h);
      for (int dc = -HALF; dc <= HALF; dc++)
        acc += rows_mem[rr % KSIZE][clamp_to(c + dc, w)];
    end
    return PIX_W'(acc / (KSIZE * KSIZE));
  endfunction

  // predict the means that one source pixel releases
  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    int w, h, r, c, r0, r1, c0, c1, first;
    mean_result_t res;
    w = eff_dim(cfg_width, MAX_WIDTH);
    h = eff_dim(cfg_height, MAX_HEIGHT);
    r = (next_row >= h) ? 0 : next_row;
    c = (next_col >= w) ? 0 : next_col;
    rows_mem[r % KSIZE][c] = pix;
    r0 = r - HALF;
    r1 = r0;
    c0 = c - HALF;
    c1 = c0;
    if (r == h - 1) begin
      r0 = (r - HALF < 0) ? 0 : r - HALF;
      r1 = r;
    end
    if (c == w - 1) begin
      c0 = (c - HALF < 0) ? 0 : c - HALF;
      c1 = c;
    end
    if (r0 >= 0 && c0 >= 0) begin
      first = pending_means.size();
      for (int rr = r0; rr <= r1; rr++)
        for (int cc = c0; cc <= c1; cc++) begin
          res.mean = box_mean(rr, cc, w, h);
          res.run_end = 1'b0;
          res.frame_end = (rr == h - 1 && cc == w - 1);
          pending_means.push_back(res);
        end
      pending_means[pending_means.size() - 1].run_end = 1'b1;
      if (first < 0) error_count++;
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
      if (r + 1 >= h) frame_count++;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  // result checking at the rising edge
  always @(posedge clk) begin
    mean_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_means.size() == 0) begin
        report_mismatch("unexpected result transfer", mean_pixel, -1);
      end else begin
        want = pending_means.pop_front();
        if (mean_pixel !== want.mean) report_mismatch("mean_pixel", mean_pixel, want.mean);
        if (run_last !== want.run_end) report_mismatch("run_last", run_last, want.run_end);
        if (frame_last !== want.frame_end)
          report_mismatch("frame_last", frame_last, want.frame_end);
      end
      result_count++;
    end
  end

  // receiver: random stall per result
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      if (hold_results_checked) stall = 0;
      repeat (stall) begin
        result_ready <= 1'b0;
        @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // register write, setup then access
  task automatic write_reg(input reg_index_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = WIDTH_REG_W'(value);
    else cfg_height = HEIGHT_REG_W'(value);
    next_col = 0;
    next_row = 0;
  endtask

  // send one pixel, gap drawn per pixel
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in    <= pix;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    predict_pixel(pix);
    @(negedge clk);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending_means.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // stimulus
  initial begin
    pixel_row_t directed[$];
    pixel_row_t row;
    int w, h, n;
    mean_result_t known_res;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pixel_valid = 1'b0;
    pixel_in = '0;
    error_count = 0;
    result_count = 0;
    frame_count = 0;
    hold_results_checked = 1'b0;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    next_col = 0;
    next_row = 0;
    foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: 3x3 frame of all 255, then a 3x3 checker, then zeros
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) begin
      row.pix = 8'hFF;
      row.known = (i == 8);
      known_res = '{mean: 8'hFF, run_end: 1'b1, frame_end: 1'b1};
      row.res = known_res;
      directed.push_back(row);
    end
    for (int i = 0; i < 9; i++) begin
      row.pix = (i % 2) ? 8'h00 : 8'hFF;
      row.known = 1'b0;
      directed.push_back(row);
    end
    for (int i = 0; i < 6; i++) begin
      row.pix = 8'h00;
      row.known = 1'b0;
      directed.push_back(row);
    end
    foreach (directed[i]) begin
      send_pixel(directed[i].pix, 1'b1);
      if (directed[i].known && pending_means.size() > 0 &&
          pending_means[pending_means.size() - 1] !== directed[i].res) begin
        report_mismatch("directed row", i, i);
      end
    end
    drain_results();

    // sizes below the kernel and out of range, through saturation
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom), 1'b1);
    drain_results();
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 8191);
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom), 1'b1);
    drain_results();
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 4096);
    for (int i = 0; i < 4; i++) send_pixel(8'($urandom), 1'b1);
    drain_results();

    // random: small frames with random content, the last one possibly partial
    n = 0;
    while (n < NUM_RANDOM) begin
      w = $urandom_range(3, 7);
      h = $urandom_range(3, 6);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      for (int i = 0; i < w * h && n < NUM_RANDOM; i++) begin
        if ($urandom_range(0, 19) == 0) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b1);
        else send_pixel(8'($urandom), ($urandom_range(0, 3) != 0));
        n++;
        // sender waits for the pipe to empty now and then
        if ($urandom_range(0, 40) == 0) begin
          pixel_valid <= 1'b0;
          @(negedge clk);
          while (pending_means.size() != 0) @(negedge clk);
        end
      end
      drain_results();
    end

    $display("covered %0d results over %0d completed frames, sizes from 1x1 to 1024x4096",
             result_count, frame_count);
    if (error_count == 0) $display("tb_box_filter_replicate_border OK");
    else $display("tb_box_filter_replicate_border NOT OK");
    $finish;
  end

endmodule
